FILE: sv/crc8_ft_pkg.sv
// Shared constants, the queue entry type and the CRC-8 byte update for the
// framed packet transmitter. Depends on nothing; every other file uses it.
`timescale 1ns / 1ps
`default_nettype none

package crc8_ft_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned NumWords   = 3;
  localparam int unsigned PayloadW   = WordW * NumWords;
  localparam int unsigned IdxW       = 5;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] HdrFirst  = 8'hAA;
  localparam logic [7:0] HdrSecond = 8'h55;
  localparam logic [7:0] CrcPoly   = 8'h07;
  localparam logic [7:0] CrcTopBit = 8'h80;
  localparam logic [7:0] TypeData  = 8'h01;
  localparam logic [7:0] TypeImp   = 8'h02;
  localparam logic [7:0] LenData   = 8'd8;
  localparam logic [7:0] LenImp    = 8'd12;

  // Byte positions inside a frame.
  localparam logic [IdxW-1:0] IdxHdrFirst  = 5'd0;
  localparam logic [IdxW-1:0] IdxHdrSecond = 5'd1;
  localparam logic [IdxW-1:0] IdxType      = 5'd2;
  localparam logic [IdxW-1:0] IdxLen       = 5'd3;
  localparam logic [IdxW-1:0] IdxPayload   = 5'd4;
  localparam logic [IdxW-1:0] IdxCrcData   = 5'd12;
  localparam logic [IdxW-1:0] IdxCrcImp    = 5'd16;

  typedef struct packed {
    logic [7:0]          type_byte;
    logic [7:0]          len_byte;
    logic [IdxW-1:0]     crc_idx;
    logic [PayloadW-1:0] words;
  } entry_t;

  // One byte through the MSB-first CRC-8, eight shift steps.
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if ((c & CrcTopBit) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: sv/crc8_ft_front.sv
// Front stage: accepts a record, classifies its kind into type, length and
// CRC position, and holds it until the queue takes it. Uses crc8_ft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crc8_ft_front (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  wire                                   in_kind_i,
  input  wire  [crc8_ft_pkg::PayloadW-1:0]      in_words_i,
  output logic                                  push_valid_o,
  input  wire                                   push_ready_i,
  output crc8_ft_pkg::entry_t                   push_entry_o
);

  logic                valid_q, valid_d;
  crc8_ft_pkg::entry_t entry_q, entry_d;
  logic                take;

  assign in_ready_o   = !valid_q || push_ready_i;
  assign take         = in_valid_i && in_ready_o;
  assign push_valid_o = valid_q;
  assign push_entry_o = entry_q;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (take) begin
      valid_d         = 1'b1;
      entry_d.words   = in_words_i;
      if (in_kind_i) begin
        entry_d.type_byte = crc8_ft_pkg::TypeImp;
        entry_d.len_byte  = crc8_ft_pkg::LenImp;
        entry_d.crc_idx   = crc8_ft_pkg::IdxCrcImp;
      end else begin
        entry_d.type_byte = crc8_ft_pkg::TypeData;
        entry_d.len_byte  = crc8_ft_pkg::LenData;
        entry_d.crc_idx   = crc8_ft_pkg::IdxCrcData;
      end
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

FILE: sv/crc8_ft_queue.sv
// Short first-in first-out queue of classified records between the front
// and the back stage. Uses crc8_ft_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module crc8_ft_queue #(
  parameter int unsigned Depth = crc8_ft_pkg::QueueDepth
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_valid_i,
  output logic                 push_ready_o,
  input  crc8_ft_pkg::entry_t  push_entry_i,
  output logic                 pop_valid_o,
  input  wire                  pop_i,
  output crc8_ft_pkg::entry_t  pop_entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  crc8_ft_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue popped while empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue fill count did not follow a push");

endmodule

`default_nettype wire

FILE: sv/crc8_ft_back.sv
// Back stage: walks the head record of the queue one frame byte per cycle
// while the output is not stalled, folds payload bytes into the CRC and
// drives the output register. Uses crc8_ft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crc8_ft_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  entry_valid_i,
  input  crc8_ft_pkg::entry_t  entry_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 out_last_o
);

  logic [crc8_ft_pkg::IdxW-1:0] idx_q, idx_d;
  logic [7:0]                   crc_q, crc_d;
  logic                         valid_q, valid_d;
  logic [7:0]                   byte_q;
  logic                         last_q;
  logic                         advance, emit;
  logic [7:0]                   cur_byte;
  logic                         cur_last;
  logic [3:0]                   pidx;
  logic [7:0]                   pay_byte;

  assign advance     = !valid_q || out_ready_i;
  assign emit        = advance && entry_valid_i;
  assign pidx        = idx_q[3:0] - 4'd4;
  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;
  assign pop_o       = emit && cur_last;

  always_comb begin
    pay_byte = 8'h00;
    for (int k = 0; k < 12; k++) begin
      if (pidx == 4'(k)) begin
        pay_byte = entry_i.words[k*8 +: 8];
      end
    end
  end

  always_comb begin
    cur_last = 1'b0;
    case (idx_q)
      crc8_ft_pkg::IdxHdrFirst:  cur_byte = crc8_ft_pkg::HdrFirst;
      crc8_ft_pkg::IdxHdrSecond: cur_byte = crc8_ft_pkg::HdrSecond;
      crc8_ft_pkg::IdxType:      cur_byte = entry_i.type_byte;
      crc8_ft_pkg::IdxLen:       cur_byte = entry_i.len_byte;
      default: begin
        if (idx_q == entry_i.crc_idx) begin
          cur_byte = crc_q;
          cur_last = 1'b1;
        end else begin
          cur_byte = pay_byte;
        end
      end
    endcase
  end

  always_comb begin
    idx_d   = idx_q;
    crc_d   = crc_q;
    valid_d = valid_q;
    if (advance) begin
      valid_d = entry_valid_i;
    end
    if (emit) begin
      if (cur_last) begin
        idx_d = '0;
        crc_d = 8'h00;
      end else begin
        idx_d = idx_q + 1'b1;
        if (idx_q >= crc8_ft_pkg::IdxPayload) begin
          crc_d = crc8_ft_pkg::crc8_feed(crc_q, pay_byte);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      crc_q   <= 8'h00;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      crc_q   <= crc_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q <= cur_byte;
      last_q <= cur_last;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= crc8_ft_pkg::IdxCrcImp)
    else $error("byte index ran past the longest frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != '0) |-> entry_valid_i)
    else $error("record left the queue in the middle of its frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && cur_last) |=> (idx_q == '0 && crc_q == 8'h00 && last_q))
    else $error("frame end did not restart the byte index and CRC");

endmodule

`default_nettype wire

FILE: sv/crc8_frame_transmitter.sv
// Top level of the CRC-8 framed packet transmitter: front stage, record
// queue and byte-serial back stage. Uses crc8_ft_pkg and the crc8_ft_* modules.
//
//   Channel   Direction  Payload
//   s_axis    in         tuser = frame_kind; tdata = word_first, word_second, word_third
//   m_axis    out        tdata = frame_byte; tlast = frame_end (on the CRC byte)
//
// Each record leaves as one frame: 0xAA, 0x55, type, length, the payload
// words least significant byte first (a data point omits word_third), then a
// CRC-8 (poly 0x07, initial zero, no reflection, no final xor) of payload only.
//
// A data point frame is 13 bytes and an impedance point frame 17 bytes, sent
// one byte per cycle from the back stage's output register unless m_axis
// stalls. The front stage and the record queue accept the next record while
// a frame is still streaming, so frames follow each other without idle cycles.
// Each record passes the front register, the queue and the output register.
// Reset clears the handshake and sequencing state; no clearing pass is needed.
// A stall on m_axis holds the current byte; the input side keeps accepting
// until the front register and the queue are full.
`timescale 1ns / 1ps
`default_nettype none

module crc8_frame_transmitter #(
  parameter int unsigned QueueDepth = crc8_ft_pkg::QueueDepth
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [95:0] s_axis_tdata,   // [31:0] word_first, [63:32] word_second,
                                      // [95:64] word_third
  input  wire         s_axis_tuser,   // [0] frame_kind
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
  output logic        m_axis_tlast    // frame_end
);

  // Classified record handed from the front stage into the queue.
  logic                push_valid, push_ready;
  crc8_ft_pkg::entry_t push_entry;

  // Head record of the queue as seen by the back stage.
  logic                head_valid, head_pop;
  crc8_ft_pkg::entry_t head_entry;

  crc8_ft_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_kind_i    (s_axis_tuser),
    .in_words_i   (s_axis_tdata),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  crc8_ft_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (head_valid),
    .pop_i        (head_pop),
    .pop_entry_o  (head_entry)
  );

  // The back stage pops the head record only while emitting its CRC byte.
  crc8_ft_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (head_valid),
    .entry_i       (head_entry),
    .pop_o         (head_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (m_axis_tdata),
    .out_last_o    (m_axis_tlast)
  );

endmodule

`default_nettype wire
